>>> src/counting_semaphore_fifo_top_defines.svh
// ----------------------------------------------------------------------------
// Counting semaphore assertion macros
// Shared concurrent assertion shorthands for the semaphore block.
// ----------------------------------------------------------------------------
`ifndef COUNTING_SEMAPHORE_FIFO_TOP_DEFINES_SVH
`define COUNTING_SEMAPHORE_FIFO_TOP_DEFINES_SVH

// same-cycle implication
`define CSF_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("semaphore assertion failed");

// next-cycle implication
`define CSF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("semaphore assertion failed");

`endif

>>> src/csf_pkg.sv
// ----------------------------------------------------------------------------
// Counting semaphore package
// Field widths, request codes, result status codes and shared structs.
// ----------------------------------------------------------------------------
`default_nettype none

package csf_pkg;

  localparam int TASK_W = 8;
  localparam int CNT_W  = 8;
  localparam int WAIT_W = 5;

  localparam logic ACT_LOCK   = 1'b0;
  localparam logic ACT_UNLOCK = 1'b1;

  typedef enum logic [2:0] {
    ST_GRANTED  = 3'd0,
    ST_QUEUED   = 3'd1,
    ST_RELEASED = 3'd2,
    ST_HANDOFF  = 3'd3,
    ST_FULL     = 3'd4,
    ST_NOTHING  = 3'd5
  } status_t;

  typedef struct packed {
    logic push;
    logic pop;
  } queue_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_stat_t;

  typedef struct packed {
    status_t             status;
    logic [TASK_W-1:0]   woken_task;
    logic [CNT_W-1:0]    holders_now;
    logic [WAIT_W-1:0]   waiters_now;
  } result_t;

endpackage

`default_nettype wire

>>> src/csf_req_if.sv
// ----------------------------------------------------------------------------
// Semaphore request channel
// Valid/ready channel carrying one lock or unlock request.
// ----------------------------------------------------------------------------
`default_nettype none

interface csf_req_if;
  import csf_pkg::*;

  logic              valid;
  logic              ready;
  logic              action;
  logic [TASK_W-1:0] task_id;

  modport source (output valid, action, task_id, input ready);
  modport sink   (input valid, action, task_id, output ready);
endinterface

`default_nettype wire

>>> src/csf_rsp_if.sv
// ----------------------------------------------------------------------------
// Semaphore result channel
// Valid/ready channel carrying the outcome of one request.
// ----------------------------------------------------------------------------
`default_nettype none

interface csf_rsp_if;
  import csf_pkg::*;

  logic              valid;
  logic              ready;
  status_t           status;
  logic [TASK_W-1:0] woken_task;
  logic [CNT_W-1:0]  holders_now;
  logic [WAIT_W-1:0] waiters_now;

  modport source (output valid, status, woken_task, holders_now, waiters_now, input ready);
  modport sink   (input valid, status, woken_task, holders_now, waiters_now, output ready);
endinterface

`default_nettype wire

>>> src/csf_queue.sv
// ----------------------------------------------------------------------------
// Semaphore wait queue
// Circular buffer of waiting task ids with a prefetched head entry.
// ----------------------------------------------------------------------------
`default_nettype none

`include "counting_semaphore_fifo_top_defines.svh"

module csf_queue #(
  parameter  int QUEUE_DEPTH = 16,
  localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire csf_pkg::queue_cmd_t        cmd,
  input  wire logic [csf_pkg::TASK_W-1:0] wdata,
  output csf_pkg::queue_stat_t            stat,
  output logic [csf_pkg::TASK_W-1:0]      head_data,
  output logic [FILL_W-1:0]               fill_after
);
  import csf_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  logic [TASK_W-1:0] mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]  head;
  logic [PTR_W-1:0]  tail;
  logic [FILL_W-1:0] fill;
  logic [PTR_W-1:0]  head_next;
  logic [PTR_W-1:0]  tail_next;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign stat.empty = (fill == '0);
  assign stat.full  = (fill == FILL_W'(QUEUE_DEPTH));

  always_comb begin
    head_next  = cmd.pop  ? ptr_inc(head) : head;
    tail_next  = cmd.push ? ptr_inc(tail) : tail;
    fill_after = fill;
    if (cmd.push) begin
      fill_after = fill + 1'b1;
    end else if (cmd.pop) begin
      fill_after = fill - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else begin
      head <= head_next;
      tail <= tail_next;
      fill <= fill_after;
    end
  end

  // head entry is prefetched from the next head pointer; a push into the head slot is forwarded
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[tail] <= wdata;
    end
    if (cmd.push && (tail == head_next)) begin
      head_data <= wdata;
    end else begin
      head_data <= mem[head_next];
    end
  end

  `CSF_ASSERT_IMP(a_fill_bound, clk, rst, 1'b1, fill <= FILL_W'(QUEUE_DEPTH))
  `CSF_ASSERT_IMP(a_no_push_full, clk, rst, cmd.push, !stat.full && !cmd.pop)
  `CSF_ASSERT_IMP(a_no_pop_empty, clk, rst, cmd.pop, !stat.empty)
  `CSF_ASSERT_NEXT(a_push_fill, clk, rst, cmd.push, fill == FILL_W'($past(fill) + 1'b1))

endmodule

`default_nettype wire

>>> src/csf_ctrl.sv
// ----------------------------------------------------------------------------
// Semaphore control
// Holder count, holder limit register and per-request decision.
// ----------------------------------------------------------------------------
`default_nettype none

module csf_ctrl #(
  parameter int FILL_W = 5
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [csf_pkg::CNT_W-1:0]  cfg_data,
  input  wire logic                       go,
  input  wire logic                       action,
  input  wire csf_pkg::queue_stat_t       qstat,
  input  wire logic [csf_pkg::TASK_W-1:0] head_data,
  input  wire logic [FILL_W-1:0]          fill_after,
  output csf_pkg::queue_cmd_t             qcmd,
  output csf_pkg::result_t                result
);
  import csf_pkg::*;

  logic [CNT_W-1:0] max_holders;
  logic [CNT_W-1:0] holder_count;
  logic [CNT_W-1:0] holder_count_next;
  queue_cmd_t       cmd;

  always_comb begin
    cmd               = '0;
    holder_count_next = holder_count;
    result            = '0;
    case (action)
      ACT_LOCK: begin
        if (holder_count < max_holders) begin
          holder_count_next = holder_count + 1'b1;
          result.status     = ST_GRANTED;
        end else if (!qstat.full) begin
          cmd.push      = 1'b1;
          result.status = ST_QUEUED;
        end else begin
          result.status = ST_FULL;
        end
      end
      ACT_UNLOCK: begin
        if (!qstat.empty) begin
          cmd.pop           = 1'b1;
          result.status     = ST_HANDOFF;
          result.woken_task = head_data;
        end else if (holder_count != '0) begin
          holder_count_next = holder_count - 1'b1;
          result.status     = ST_RELEASED;
        end else begin
          result.status = ST_NOTHING;
        end
      end
      default: begin
        result.status = ST_NOTHING;
      end
    endcase
    result.holders_now = holder_count_next;
    result.waiters_now = WAIT_W'(fill_after);
    qcmd.push          = go && cmd.push;
    qcmd.pop           = go && cmd.pop;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_holders  <= CNT_W'(1);
      holder_count <= '0;
    end else begin
      if (cfg_we) begin
        max_holders <= cfg_data;
      end
      if (go) begin
        holder_count <= holder_count_next;
      end
    end
  end

endmodule

`default_nettype wire

>>> src/counting_semaphore_fifo_top.sv
// ----------------------------------------------------------------------------
// Counting semaphore with FIFO wait queue
// Request register, decision and queue update, result register.
// ----------------------------------------------------------------------------
// Accepts one lock or unlock request per cycle while results are taken and
// returns one result per request via the request register and the result
// register. The holder count and the queue pointers settle between those
// registers, so back-to-back requests each see the state left by the one
// before. Lock requests beyond max_holders wait in a QUEUE_DEPTH-entry FIFO
// (ST_FULL if it is full); an unlock hands ownership to the oldest waiter.
// A max_holders write takes effect for the next request processed.
`default_nettype none

module counting_semaphore_fifo_top #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  csf_req_if.sink                        req,
  csf_rsp_if.source                      rsp,
  input  wire logic                      cfg_we,
  input  wire logic [csf_pkg::CNT_W-1:0] cfg_data
);
  import csf_pkg::*;

  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  logic              req_valid;
  logic              req_action;
  logic [TASK_W-1:0] req_task;
  logic              rsp_valid;
  result_t           rsp_data;
  logic              go;

  queue_cmd_t        qcmd;
  queue_stat_t       qstat;
  logic [TASK_W-1:0] head_data;
  logic [FILL_W-1:0] fill_after;
  result_t           result;

  assign go        = req_valid && (!rsp_valid || rsp.ready);
  assign req.ready = !req_valid || go;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (req.ready) begin
      req_valid <= req.valid;
    end
    if (req.valid && req.ready) begin
      req_action <= req.action;
      req_task   <= req.task_id;
    end
  end

  csf_ctrl #(
    .FILL_W (FILL_W)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .go         (go),
    .action     (req_action),
    .qstat      (qstat),
    .head_data  (head_data),
    .fill_after (fill_after),
    .qcmd       (qcmd),
    .result     (result)
  );

  csf_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .cmd        (qcmd),
    .wdata      (req_task),
    .stat       (qstat),
    .head_data  (head_data),
    .fill_after (fill_after)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (go) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
    if (go) begin
      rsp_data <= result;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.status      = rsp_data.status;
  assign rsp.woken_task  = rsp_data.woken_task;
  assign rsp.holders_now = rsp_data.holders_now;
  assign rsp.waiters_now = rsp_data.waiters_now;

endmodule

`default_nettype wire
